>>> design/isc_pkg.sv
// ---------------------------------------------------------------------------
// isc_pkg
// Shared types and codes for the interval set coalescer: beat payloads,
// controller states, and the command/status bundles between the controller
// and the datapath.
// ---------------------------------------------------------------------------
package isc_pkg;

    localparam int VALUE_W = 16;
    localparam int COUNT_W = 6;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DUMP   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_PRESENT  = 3'd0,
        ST_EXTENDED = 3'd1,
        ST_MERGED   = 3'd2,
        ST_NEW      = 3'd3,
        ST_FULL     = 3'd4,
        ST_DUMP     = 3'd5,
        ST_EMPTY    = 3'd6,
        ST_CLEARED  = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MCHECK,
        S_MERGE,
        S_FINISH,
        S_DUMP
    } state_t;

    typedef enum logic [1:0] {
        RD_HIT,
        RD_MERGE,
        RD_DUMP
    } rd_src_t;

    typedef enum logic [1:0] {
        RNG_CELL,
        RNG_VALUE,
        RNG_ZERO
    } rng_src_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [VALUE_W-1:0] value;
    } isc_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [VALUE_W-1:0] range_low;
        logic [VALUE_W-1:0] range_high;
        logic [COUNT_W-1:0] interval_count;
        logic               last;
    } isc_out_t;

    typedef struct packed {
        logic     load;
        logic     scan;
        logic     grow;
        logic     append;
        logic     mcheck;
        logic     merge;
        logic     clear;
        logic     dump_start;
        logic     dump_step;
        logic     emit;
        status_t  status;
        rng_src_t rng_src;
        rd_src_t  rd_src;
        logic     last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit_found;
        logic hit_inside;
        logic merge_found;
        logic full;
        logic count_zero;
        logic dump_last;
    } dp_stat_t;

endpackage

>>> design/isc_ctrl.sv
// ---------------------------------------------------------------------------
// isc_ctrl
// Controller state machine: sequences scan, grow, merge check, compaction,
// append, dump and clear steps in the datapath.
// ---------------------------------------------------------------------------
module isc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         op,
    input  isc_pkg::dp_stat_t  stat,
    output isc_pkg::ctrl_cmd_t cmd,
    output logic               busy
);

    isc_pkg::state_t state_reg;
    isc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (op == isc_pkg::OP_INSERT)
                    begin
                        state_next = isc_pkg::S_SCAN;
                    end
                    else if (op == isc_pkg::OP_DUMP && !stat.count_zero)
                    begin
                        state_next = isc_pkg::S_DUMP;
                    end
                end
            end
            isc_pkg::S_SCAN:
            begin
                state_next = isc_pkg::S_DECIDE;
            end
            isc_pkg::S_DECIDE:
            begin
                if (stat.hit_found && !stat.hit_inside)
                begin
                    state_next = isc_pkg::S_MCHECK;
                end
                else
                begin
                    state_next = isc_pkg::S_IDLE;
                end
            end
            isc_pkg::S_MCHECK:
            begin
                state_next = isc_pkg::S_MERGE;
            end
            isc_pkg::S_MERGE:
            begin
                if (stat.merge_found)
                begin
                    state_next = isc_pkg::S_FINISH;
                end
                else
                begin
                    state_next = isc_pkg::S_IDLE;
                end
            end
            isc_pkg::S_FINISH:
            begin
                state_next = isc_pkg::S_IDLE;
            end
            isc_pkg::S_DUMP:
            begin
                if (stat.dump_last)
                begin
                    state_next = isc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = isc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.status  = isc_pkg::ST_PRESENT;
        cmd.rng_src = isc_pkg::RNG_ZERO;
        cmd.rd_src  = isc_pkg::RD_HIT;
        busy        = (state_reg != isc_pkg::S_IDLE);
        case (state_reg)
            isc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        isc_pkg::OP_INSERT:
                        begin
                            cmd.load = 1'b1;
                        end
                        isc_pkg::OP_DUMP:
                        begin
                            if (stat.count_zero)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = isc_pkg::ST_EMPTY;
                                cmd.last   = 1'b1;
                            end
                            else
                            begin
                                cmd.dump_start = 1'b1;
                            end
                        end
                        isc_pkg::OP_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            cmd.emit   = 1'b1;
                            cmd.status = isc_pkg::ST_CLEARED;
                            cmd.last   = 1'b1;
                        end
                        default:
                        begin
                            cmd.emit = 1'b0;
                        end
                    endcase
                end
            end
            isc_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            isc_pkg::S_DECIDE:
            begin
                if (stat.hit_inside)
                begin
                    cmd.emit    = 1'b1;
                    cmd.status  = isc_pkg::ST_PRESENT;
                    cmd.rng_src = isc_pkg::RNG_CELL;
                    cmd.last    = 1'b1;
                end
                else if (stat.hit_found)
                begin
                    cmd.grow = 1'b1;
                end
                else if (stat.full)
                begin
                    cmd.emit    = 1'b1;
                    cmd.status  = isc_pkg::ST_FULL;
                    cmd.rng_src = isc_pkg::RNG_VALUE;
                    cmd.last    = 1'b1;
                end
                else
                begin
                    cmd.append  = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.status  = isc_pkg::ST_NEW;
                    cmd.rng_src = isc_pkg::RNG_VALUE;
                    cmd.last    = 1'b1;
                end
            end
            isc_pkg::S_MCHECK:
            begin
                cmd.mcheck = 1'b1;
            end
            isc_pkg::S_MERGE:
            begin
                if (stat.merge_found)
                begin
                    cmd.merge  = 1'b1;
                    cmd.rd_src = isc_pkg::RD_MERGE;
                end
                else
                begin
                    cmd.emit    = 1'b1;
                    cmd.status  = isc_pkg::ST_EXTENDED;
                    cmd.rng_src = isc_pkg::RNG_CELL;
                    cmd.last    = 1'b1;
                end
            end
            isc_pkg::S_FINISH:
            begin
                cmd.emit    = 1'b1;
                cmd.status  = isc_pkg::ST_MERGED;
                cmd.rng_src = isc_pkg::RNG_CELL;
                cmd.last    = 1'b1;
            end
            isc_pkg::S_DUMP:
            begin
                cmd.emit      = 1'b1;
                cmd.status    = isc_pkg::ST_DUMP;
                cmd.rng_src   = isc_pkg::RNG_CELL;
                cmd.rd_src    = isc_pkg::RD_DUMP;
                cmd.last      = stat.dump_last;
                cmd.dump_step = 1'b1;
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

>>> design/isc_dpath.sv
// ---------------------------------------------------------------------------
// isc_dpath
// Interval cell row with row-wide compare, priority pick, compaction shift,
// held count and the registered result beat.
// ---------------------------------------------------------------------------
module isc_dpath #(
    parameter int N  = 32,
    parameter int VB = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  isc_pkg::isc_in_t   item,
    input  isc_pkg::ctrl_cmd_t cmd,
    output isc_pkg::dp_stat_t  stat,
    output isc_pkg::isc_out_t  result,
    output logic               result_valid
);

    localparam int IDX_W = $clog2(N);
    localparam int CNT_W = $clog2(N + 1);

    logic [VB-1:0]    low_reg  [N];
    logic [VB-1:0]    high_reg [N];
    logic [VB-1:0]    low_next [N];
    logic [VB-1:0]    high_next[N];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [VB-1:0]    val_reg, val_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             hit_found_reg, hit_found_next;
    logic             hit_inside_reg, hit_inside_next;
    logic             ext_low_reg, ext_low_next;
    logic [IDX_W-1:0] merge_idx_reg, merge_idx_next;
    logic             merge_found_reg, merge_found_next;
    logic [VB-1:0]    cur_lo_reg, cur_lo_next;
    logic [VB-1:0]    cur_hi_reg, cur_hi_next;
    logic [IDX_W-1:0] dump_idx_reg, dump_idx_next;
    isc_pkg::isc_out_t result_reg, result_next;
    logic             valid_reg, valid_next;

    logic [N-1:0]     live_vec;
    logic [N-1:0]     inside_vec;
    logic [N-1:0]     adjl_vec;
    logic [N-1:0]     hit_vec;
    logic [N-1:0]     madj_vec;
    logic [IDX_W-1:0] p_idx;
    logic [IDX_W-1:0] m_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [VB-1:0]    rd_lo, rd_hi;
    logic [VB-1:0]    un_lo, un_hi;

    // single read port over the cell row
    always_comb
    begin
        case (cmd.rd_src)
            isc_pkg::RD_MERGE: rd_idx = merge_idx_reg;
            isc_pkg::RD_DUMP:  rd_idx = dump_idx_reg;
            default:           rd_idx = hit_idx_reg;
        endcase
    end

    assign rd_lo = low_reg[rd_idx];
    assign rd_hi = high_reg[rd_idx];

    // row-wide compare: against the value for the scan, against the grown
    // interval (held at the read port) for the merge check
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            live_vec[k]   = (CNT_W'(k) < count_reg);
            inside_vec[k] = (val_reg >= low_reg[k]) && (val_reg <= high_reg[k]);
            adjl_vec[k]   = (low_reg[k] != '0) && (val_reg == low_reg[k] - 1'b1);
            hit_vec[k]    = live_vec[k] && (inside_vec[k] || adjl_vec[k] ||
                            ((high_reg[k] != '1) && (val_reg == high_reg[k] + 1'b1)));
            madj_vec[k]   = live_vec[k] && (CNT_W'(k) > CNT_W'(hit_idx_reg)) &&
                            (((rd_hi != '1) && (low_reg[k] == rd_hi + 1'b1)) ||
                             ((rd_lo != '0) && (high_reg[k] == rd_lo - 1'b1)));
        end
    end

    // first match wins
    always_comb
    begin
        p_idx = '0;
        m_idx = '0;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (hit_vec[k])
            begin
                p_idx = IDX_W'(k);
            end
            if (madj_vec[k])
            begin
                m_idx = IDX_W'(k);
            end
        end
    end

    assign un_lo = (rd_lo < cur_lo_reg) ? rd_lo : cur_lo_reg;
    assign un_hi = (rd_hi > cur_hi_reg) ? rd_hi : cur_hi_reg;

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            low_next[k]  = low_reg[k];
            high_next[k] = high_reg[k];
        end
        count_next = count_reg;

        if (cmd.clear)
        begin
            count_next = '0;
        end

        if (cmd.grow)
        begin
            if (ext_low_reg)
            begin
                low_next[hit_idx_reg] = val_reg;
            end
            else
            begin
                high_next[hit_idx_reg] = val_reg;
            end
        end

        if (cmd.append)
        begin
            low_next[count_reg[IDX_W-1:0]]  = val_reg;
            high_next[count_reg[IDX_W-1:0]] = val_reg;
            count_next = count_reg + 1'b1;
        end

        if (cmd.merge)
        begin
            // close the gap left by the absorbed entry
            for (int k = 0; k < N - 1; k++)
            begin
                if (CNT_W'(k) >= CNT_W'(merge_idx_reg))
                begin
                    low_next[k]  = low_reg[k + 1];
                    high_next[k] = high_reg[k + 1];
                end
            end
            low_next[hit_idx_reg]  = un_lo;
            high_next[hit_idx_reg] = un_hi;
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        val_next         = val_reg;
        hit_idx_next     = hit_idx_reg;
        hit_found_next   = hit_found_reg;
        hit_inside_next  = hit_inside_reg;
        ext_low_next     = ext_low_reg;
        merge_idx_next   = merge_idx_reg;
        merge_found_next = merge_found_reg;
        cur_lo_next      = cur_lo_reg;
        cur_hi_next      = cur_hi_reg;
        dump_idx_next    = dump_idx_reg;

        if (cmd.load)
        begin
            val_next = VB'(item.value);
        end
        if (cmd.scan)
        begin
            hit_idx_next    = p_idx;
            hit_found_next  = |hit_vec;
            // stale cells past the held count never count as a hit
            hit_inside_next = hit_vec[p_idx] && inside_vec[p_idx];
            ext_low_next    = adjl_vec[p_idx];
        end
        if (cmd.mcheck)
        begin
            merge_idx_next   = m_idx;
            merge_found_next = |madj_vec;
            cur_lo_next      = rd_lo;
            cur_hi_next      = rd_hi;
        end
        if (cmd.dump_start)
        begin
            dump_idx_next = '0;
        end
        else if (cmd.dump_step)
        begin
            dump_idx_next = dump_idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        valid_next                = cmd.emit;
        result_next.status        = cmd.status;
        result_next.interval_count = isc_pkg::COUNT_W'(count_next);
        result_next.last          = cmd.last;
        case (cmd.rng_src)
            isc_pkg::RNG_CELL:
            begin
                result_next.range_low  = isc_pkg::VALUE_W'(rd_lo);
                result_next.range_high = isc_pkg::VALUE_W'(rd_hi);
            end
            isc_pkg::RNG_VALUE:
            begin
                result_next.range_low  = isc_pkg::VALUE_W'(val_reg);
                result_next.range_high = isc_pkg::VALUE_W'(val_reg);
            end
            default:
            begin
                result_next.range_low  = '0;
                result_next.range_high = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            hit_found_reg   <= 1'b0;
            hit_inside_reg  <= 1'b0;
            ext_low_reg     <= 1'b0;
            merge_found_reg <= 1'b0;
            hit_idx_reg     <= '0;
            merge_idx_reg   <= '0;
            dump_idx_reg    <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            hit_found_reg   <= hit_found_next;
            hit_inside_reg  <= hit_inside_next;
            ext_low_reg     <= ext_low_next;
            merge_found_reg <= merge_found_next;
            hit_idx_reg     <= hit_idx_next;
            merge_idx_reg   <= merge_idx_next;
            dump_idx_reg    <= dump_idx_next;
            valid_reg       <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            low_reg[k]  <= low_next[k];
            high_reg[k] <= high_next[k];
        end
        val_reg    <= val_next;
        cur_lo_reg <= cur_lo_next;
        cur_hi_reg <= cur_hi_next;
        result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

    assign stat.hit_found   = hit_found_reg;
    assign stat.hit_inside  = hit_inside_reg;
    assign stat.merge_found = merge_found_reg;
    assign stat.full        = (count_reg >= CNT_W'(N));
    assign stat.count_zero  = (count_reg == '0);
    assign stat.dump_last   = (CNT_W'(CNT_W'(dump_idx_reg) + 1'b1) == count_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(N))
        else $error("held count beyond table size");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> (count_reg < CNT_W'(N)) && !hit_found_reg)
        else $error("append with full table or with a matching interval");

    a_merge_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |-> hit_found_reg && (merge_idx_reg > hit_idx_reg))
        else $error("absorbed entry not after the grown one");

    a_merge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("merge did not drop one interval");
`endif

endmodule

>>> design/interval_set_coalescer_core.sv
// ---------------------------------------------------------------------------
// interval_set_coalescer_core
// Ordered table of disjoint, non-adjacent intervals with insert, dump and
// clear commands.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each result beat
// shows on result for one cycle with result_valid in the cycle after the step
// that makes it, and cannot be held off. An insert runs a registered row-wide
// compare over the cell array for the scan and then decides whether the value
// is already held, is appended or is dropped. When it extends an interval,
// another registered row-wide compare over the cell array does the merge
// check, and when that extension also absorbs a neighbor, one compaction
// shift follows. A dump gives one beat per held interval, and a clear or a
// dump of an empty table gives a single beat. Op code 3 is ignored.
module interval_set_coalescer_core #(
    parameter int MAX_INTERVALS = 32,
    parameter int VALUE_BITS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  isc_pkg::isc_in_t  item,
    output logic              busy,
    output isc_pkg::isc_out_t result,
    output logic              result_valid
);

    isc_pkg::ctrl_cmd_t cmd;
    isc_pkg::dp_stat_t  stat;

    isc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    isc_dpath #(
        .N  (MAX_INTERVALS),
        .VB (VALUE_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
